@@ rtl/mm_pkg.sv @@
package mm_pkg;

    // Field widths of the stream payload
    localparam int CMD_W   = 2;
    localparam int POS_W   = 3;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 35;

    // Configuration registers
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MAC,
        S_PUT
    } t_state;

    // Sequencer to MAC unit
    typedef struct packed {
        logic step;   // operand read issued this cycle
        logic clear;  // zero the accumulator
    } t_mac_ctl;

endpackage

@@ rtl/matrix_multiply.sv @@
// Loads: one beat per cycle while no compute run is busy, ready again in the next cycle.
// Compute: each C element takes K operand reads through the shared MAC, then drains the
// store read, multiply and accumulate stages and is handed over to the result register;
// a run covers M * N elements and is held up while the result side stalls.
// Synchronous active-low reset clears control state and sets all dimensions to 8;
// the A and B stores are not cleared.
module matrix_multiply #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // command, row_index, col_index,
                                                        // element_value
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [47:0]                  m_axis_tdata,  // out_row, out_col, product_value
    output logic                         m_axis_tlast   // last_element
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [CMD_W-1:0]        w_cmd;
    logic [POS_W-1:0]        w_row;
    logic [POS_W-1:0]        w_col;
    logic signed [VAL_W-1:0] w_value;
    logic                    w_we_a;
    logic                    w_we_b;
    logic [AW-1:0]           w_waddr;
    logic [ELEM_BITS-1:0]    w_wdata;
    logic [AW-1:0]           w_raddr_a;
    logic [AW-1:0]           w_raddr_b;
    logic [ELEM_BITS-1:0]    w_a;
    logic [ELEM_BITS-1:0]    w_b;
    t_mac_ctl                w_mac;
    logic                    w_busy;
    logic [ACC_W-1:0]        w_acc;
    logic [POS_W-1:0]        w_out_row;
    logic [POS_W-1:0]        w_out_col;
    logic [ACC_W-1:0]        w_out_value;

    // Unpack input beat
    assign w_cmd   = s_axis_tdata[1:0];
    assign w_row   = s_axis_tdata[4:2];
    assign w_col   = s_axis_tdata[7:5];
    assign w_value = s_axis_tdata[23:8];

    mm_ctrl #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (w_cmd),
        .i_row      (w_row),
        .i_col      (w_col),
        .i_value    (w_value),
        .o_we_a     (w_we_a),
        .o_we_b     (w_we_b),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .o_mac      (w_mac),
        .i_mac_busy (w_busy),
        .i_acc      (w_acc),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_row      (w_out_row),
        .o_col      (w_out_col),
        .o_value    (w_out_value),
        .o_last     (m_axis_tlast)
    );

    // A store
    mm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_BITS)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_a)
    );

    // B store
    mm_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_BITS)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_b),
        .o_rdata (w_b)
    );

    mm_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_busy  (w_busy),
        .o_acc   (w_acc)
    );

    // Pack result beat
    assign m_axis_tdata = {7'd0, w_out_value, w_out_col, w_out_row};

endmodule

@@ rtl/mm_ram.sv @@
module mm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mm_mac.sv @@
module mm_mac #(
    parameter int ELEM_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mm_pkg::t_mac_ctl            i_ctl,
    input  logic signed [ELEM_BITS-1:0] i_a,
    input  logic signed [ELEM_BITS-1:0] i_b,
    output logic                        o_busy,
    output logic [mm_pkg::ACC_W-1:0]    o_acc
);
    import mm_pkg::*;

    logic                          r_v1;
    logic                          r_v2;
    logic signed [2*ELEM_BITS-1:0] r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       w_prod_ext;

    // Pipeline tags: operands valid, product valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.step;
            r_v2 <= r_v1;
        end
    end

    // Shared multiplier, registered
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= i_a * i_b;
        end
    end

    // Sign-extend or wrap the product to accumulator width
    assign w_prod_ext = ACC_W'(r_prod);

    // Accumulator, wraps modulo 2^ACC_W
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    assign o_busy = r_v1 | r_v2;
    assign o_acc  = r_acc;

endmodule

@@ rtl/mm_ctrl.sv @@
module mm_ctrl #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration
    input  logic                                     i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]             i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]                 i_cfg_data,
    // input beats
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [mm_pkg::CMD_W-1:0]                 i_cmd,
    input  logic [mm_pkg::POS_W-1:0]                 i_row,
    input  logic [mm_pkg::POS_W-1:0]                 i_col,
    input  logic signed [mm_pkg::VAL_W-1:0]          i_value,
    // stores
    output logic                                     o_we_a,
    output logic                                     o_we_b,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       o_waddr,
    output logic [ELEM_BITS-1:0]                     o_wdata,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       o_raddr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       o_raddr_b,
    // MAC unit
    output mm_pkg::t_mac_ctl                         o_mac,
    input  logic                                     i_mac_busy,
    input  logic [mm_pkg::ACC_W-1:0]                 i_acc,
    // result beats
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [mm_pkg::POS_W-1:0]                 o_row,
    output logic [mm_pkg::POS_W-1:0]                 o_col,
    output logic [mm_pkg::ACC_W-1:0]                 o_value,
    output logic                                     o_last
);
    import mm_pkg::*;

    localparam int AW    = $clog2(MAX_DIM*MAX_DIM);
    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM+1);
    localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

    t_state           r_state;
    t_state           n_state;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_inner;
    logic [CFG_W-1:0] r_cols;
    logic [IDX_W-1:0] r_r;
    logic [IDX_W-1:0] r_c;
    logic [CNT_W-1:0] r_p;
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_row;
    logic [POS_W-1:0] r_out_col;
    logic [ACC_W-1:0] r_out_value;
    logic             r_out_last;

    logic [CFG_W-1:0] w_m;
    logic [CFG_W-1:0] w_k;
    logic [CFG_W-1:0] w_n;
    logic             w_accept;
    logic             w_pos_ok;
    logic             w_load_a;
    logic             w_load_b;
    logic             w_go;
    logic             w_step;
    logic             w_out_load;
    logic             w_row_end;
    logic             w_last;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= CFG_DIM_RESET;
            r_inner <= CFG_DIM_RESET;
            r_cols  <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROWS:  r_rows  <= i_cfg_data;
                REG_INNER: r_inner <= i_cfg_data;
                REG_COLS:  r_cols  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Dimensions above the array size act as the array size
    assign w_m = (r_rows  > DIM_MAX) ? DIM_MAX : r_rows;
    assign w_k = (r_inner > DIM_MAX) ? DIM_MAX : r_inner;
    assign w_n = (r_cols  > DIM_MAX) ? DIM_MAX : r_cols;

    // Input decode
    always_comb begin
        w_load_a = 1'b0;
        w_load_b = 1'b0;
        w_go     = 1'b0;
        unique case (i_cmd) inside
            CMD_LOAD_A, CMD_LOAD_B: begin
                w_load_a = w_accept && w_pos_ok && (i_cmd == CMD_LOAD_A);
                w_load_b = w_accept && w_pos_ok && (i_cmd == CMD_LOAD_B);
            end
            CMD_COMPUTE: begin
                w_go = w_accept && (w_m != '0) && (w_n != '0);
            end
            default: ;
        endcase
    end

    assign w_accept = i_valid && o_ready;
    assign w_pos_ok = ({1'b0, i_row} < DIM_MAX) && ({1'b0, i_col} < DIM_MAX);

    // Store write port
    assign o_we_a  = w_load_a;
    assign o_we_b  = w_load_b;
    assign o_waddr = AW'(i_row) * AW'(MAX_DIM) + AW'(i_col);
    assign o_wdata = ELEM_BITS'(i_value);

    // Operand addresses: A[r][p] and B[p][c]
    assign o_raddr_a = AW'(r_r) * AW'(MAX_DIM) + AW'(r_p[IDX_W-1:0]);
    assign o_raddr_b = AW'(r_p[IDX_W-1:0]) * AW'(MAX_DIM) + AW'(r_c);

    assign w_row_end = (CFG_W'(r_c) + CFG_W'(1)) == w_n;
    assign w_last    = w_row_end && ((CFG_W'(r_r) + CFG_W'(1)) == w_m);

    // Sequencer outputs
    always_comb begin
        o_ready    = 1'b0;
        w_step     = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready    = 1'b1;
            S_MAC:  w_step     = CFG_W'(r_p) < w_k;
            S_PUT:  w_out_load = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    assign o_mac.step  = w_step;
    assign o_mac.clear = w_go || w_out_load;

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_go) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (!w_step && !i_mac_busy) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (w_out_load) begin
                    n_state = w_last ? S_IDLE : S_MAC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Row, column and inner counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r <= '0;
            r_c <= '0;
            r_p <= '0;
        end else if (w_go) begin
            r_r <= '0;
            r_c <= '0;
            r_p <= '0;
        end else if (w_step) begin
            r_p <= r_p + CNT_W'(1);
        end else if (w_out_load) begin
            r_p <= '0;
            if (w_row_end) begin
                r_c <= '0;
                r_r <= r_r + IDX_W'(1);
            end else begin
                r_c <= r_c + IDX_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_row   <= POS_W'(r_r);
            r_out_col   <= POS_W'(r_c);
            r_out_value <= i_acc;
            r_out_last  <= w_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule

@@ tb/matrix_multiply_tb.sv @@
`timescale 1ns / 1ps

module matrix_multiply_tb;

    import mm_pkg::*;

    localparam int MAX_DIM      = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;

    // Command 3 has no meaning; the block drops it
    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    // Index 3 selects no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    // One element of C as it leaves the block
    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [ACC_W-1:0] sum;
        logic                    last;
    } t_c_elem;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata;   // command, row_index, col_index, element_value
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [47:0]          m_axis_tdata;   // out_row, out_col, product_value
    logic                 m_axis_tlast;   // last_element

    // Own copy of the operand stores and dimensions
    logic signed [VAL_W-1:0] a_mat [MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] b_mat [MAX_DIM*MAX_DIM];
    bit                      a_known [MAX_DIM*MAX_DIM];
    bit                      b_known [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0]        rows_cfg  = CFG_DIM_RESET;
    logic [CFG_W-1:0]        inner_cfg = CFG_DIM_RESET;
    logic [CFG_W-1:0]        cols_cfg  = CFG_DIM_RESET;

    t_c_elem c_elems_due [$];

    int fail_count   = 0;
    int items_sent   = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    matrix_multiply i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Dimension register as the block sees it: anything above MAX_DIM is MAX_DIM
    function automatic int eff_dim(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // Element values lean towards the extremes
    function automatic logic [VAL_W-1:0] pick_element();
        case ($urandom_range(7, 0))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly small dimensions, sometimes zero, full or above full
    function automatic logic [CFG_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 70)
            return 4'($urandom_range(3, 1));
        if (roll < 82)
            return 4'($urandom_range(8, 4));
        if (roll < 90)
            return 4'd0;
        return 4'($urandom_range(15, 9));
    endfunction

    // Update the stores or queue the C elements due for one accepted beat
    function automatic void apply_beat(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                                       input logic [POS_W-1:0] col,
                                       input logic [VAL_W-1:0] value);
        int      m;
        int      k;
        int      n;
        longint  acc;
        t_c_elem e;
        m = eff_dim(rows_cfg);
        k = eff_dim(inner_cfg);
        n = eff_dim(cols_cfg);
        case (cmd)
            CMD_LOAD_A: begin
                a_mat[{row, col}]   = value;
                a_known[{row, col}] = 1'b1;
            end
            CMD_LOAD_B: begin
                b_mat[{row, col}]   = value;
                b_known[{row, col}] = 1'b1;
            end
            CMD_COMPUTE: begin
                for (int r = 0; r < m; r++) begin
                    for (int c = 0; c < n; c++) begin
                        acc = 0;
                        for (int p = 0; p < k; p++)
                            acc += longint'(a_mat[r*MAX_DIM+p]) * longint'(b_mat[p*MAX_DIM+c]);
                        e.row  = POS_W'(r);
                        e.col  = POS_W'(c);
                        e.sum  = acc[ACC_W-1:0];
                        e.last = (r == m - 1) && (c == n - 1);
                        c_elems_due.push_back(e);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Result side: check each beat, stall at random or for a requested hold-off
    always @(posedge i_clk) begin
        t_c_elem got;
        t_c_elem want;
        if (m_axis_tvalid && m_axis_tready) begin
            got.row  = m_axis_tdata[2:0];
            got.col  = m_axis_tdata[5:3];
            got.sum  = m_axis_tdata[40:6];
            got.last = m_axis_tlast;
            if (c_elems_due.size() == 0) begin
                $error("result beat with nothing expected: row %0d col %0d", got.row, got.col);
                fail_count++;
            end else begin
                want = c_elems_due.pop_front();
                if (got.row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, got.row);
                    fail_count++;
                end
                if (got.col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, got.col);
                    fail_count++;
                end
                if (got.sum !== want.sum) begin
                    $error("product_value: expected %0d, got %0d", want.sum, got.sum);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $error("last_element: expected %0d, got %0d", want.last, got.last);
                    fail_count++;
                end
            end
        end
        if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    // One input beat; tvalid stays high on return so back-to-back beats need no gap
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col, input logic [VAL_W-1:0] value);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, col, row, cmd};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        apply_beat(cmd, row, col, value);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Drop tvalid and wait until every C element is out and the block has gone quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (c_elems_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ROWS:  rows_cfg  = value;
            REG_INNER: inner_cfg = value;
            REG_COLS:  cols_cfg  = value;
            default:   ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] k,
                            input logic [CFG_W-1:0] n);
        settle_block();
        write_reg(REG_ROWS, m);
        write_reg(REG_INNER, k);
        write_reg(REG_COLS, n);
    endtask

    // Load every operand the next compute reads that has not been loaded yet
    task automatic fill_operands();
        int m;
        int k;
        int n;
        m = eff_dim(rows_cfg);
        k = eff_dim(inner_cfg);
        n = eff_dim(cols_cfg);
        for (int r = 0; r < m; r++)
            for (int p = 0; p < k; p++)
                if (!a_known[r*MAX_DIM+p])
                    send_beat(CMD_LOAD_A, POS_W'(r), POS_W'(p), pick_element());
        for (int p = 0; p < k; p++)
            for (int c = 0; c < n; c++)
                if (!b_known[p*MAX_DIM+c])
                    send_beat(CMD_LOAD_B, POS_W'(p), POS_W'(c), pick_element());
    endtask

    // Field extremes, ignored fields, unused command and odd register values
    task automatic test_directed_cases();
        set_dims(4'd1, 4'd1, 4'd1);
        send_beat(CMD_LOAD_A, 3'd0, 3'd0, 16'h8000);
        send_beat(CMD_LOAD_B, 3'd0, 3'd0, 16'h8000);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        send_beat(CMD_LOAD_B, 3'd0, 3'd0, 16'h7fff);
        // compute ignores index and value fields
        send_beat(CMD_COMPUTE, 3'd7, 3'd7, 16'hffff);
        send_beat(CMD_LOAD_A, 3'd0, 3'd0, 16'h7fff);
        send_beat(CMD_COMPUTE, 3'd5, 3'd2, 16'h1234);
        // unused command must leave the stores alone
        send_beat(CMD_UNUSED, 3'd0, 3'd0, 16'hffff);
        send_beat(CMD_UNUSED, 3'd7, 3'd7, 16'h0000);
        send_beat(CMD_LOAD_A, 3'd7, 3'd7, 16'hffff);
        send_beat(CMD_LOAD_B, 3'd7, 3'd7, 16'h0001);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        // zero rows or columns: nothing comes out
        set_dims(4'd0, 4'd1, 4'd1);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        set_dims(4'd1, 4'd1, 4'd0);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        // zero inner dimension: every sum is zero, nothing is read
        set_dims(4'd1, 4'd0, 4'd1);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        // above MAX_DIM acts as MAX_DIM
        set_dims(4'd15, 4'd0, 4'd1);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        set_dims(4'd1, 4'd0, 4'd9);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        // small 2x2x2 product, then a write to the spare index must change nothing
        set_dims(4'd2, 4'd2, 4'd2);
        fill_operands();
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        settle_block();
        write_reg(REG_SPARE, 4'hf);
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
    endtask

    // Well-formed load and compute runs with random content, plus some noise
    task automatic test_random_runs(input int n_items);
        int          first;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        first = items_sent;
        while (items_sent - first < n_items) begin
            set_dims(pick_dim(), pick_dim(), pick_dim());
            repeat ($urandom_range(3, 1)) begin
                repeat ($urandom_range(6, 0)) begin
                    // each index lands near the origin half the time, where small runs read it
                    row = $urandom_range(1, 0) ? 3'($urandom_range(7, 0)) : 3'($urandom_range(1, 0));
                    col = $urandom_range(1, 0) ? 3'($urandom_range(7, 0)) : 3'($urandom_range(1, 0));
                    case ($urandom_range(9, 0))
                        0:       send_beat(CMD_UNUSED, row, col, 16'($urandom));
                        1, 2, 3, 4: send_beat(CMD_LOAD_A, row, col, pick_element());
                        default: send_beat(CMD_LOAD_B, row, col, pick_element());
                    endcase
                end
                fill_operands();
                send_beat(CMD_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
            end
        end
    endtask

    // Full 8x8x8 at the most positive sum, with the result side held off so input backs up
    task automatic test_full_size_under_hold();
        set_dims(4'd8, 4'd15, 4'd8);
        for (int i = 0; i < MAX_DIM * MAX_DIM; i++) begin
            send_beat(CMD_LOAD_A, 3'(i / MAX_DIM), 3'(i % MAX_DIM), 16'h8000);
            send_beat(CMD_LOAD_B, 3'(i / MAX_DIM), 3'(i % MAX_DIM), 16'h8000);
        end
        hold_asked++;
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
        repeat (6)
            send_beat($urandom_range(1, 0) ? CMD_LOAD_B : CMD_LOAD_A,
                      3'($urandom), 3'($urandom), pick_element());
        send_beat(CMD_COMPUTE, 3'd0, 3'd0, 16'h0000);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_ROWS;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender rarely idle, receiver often stalls
        src_idle_pct = 6;
        snk_idle_pct = 56;
        test_directed_cases();
        test_random_runs(16);

        // the other way round
        src_idle_pct = 56;
        snk_idle_pct = 6;
        test_random_runs(16);

        // no idling at all
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_full_size_under_hold();
        test_random_runs(16);

        settle_block();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mm_pkg.sv
rtl/mm_ram.sv
rtl/mm_mac.sv
rtl/mm_ctrl.sv
rtl/matrix_multiply.sv
tb/matrix_multiply_tb.sv
